### src/kfm_pkg.sv
// ----------------------------------------------------------------------------
// kfm_pkg: shared types and constants of the multichannel Kalman filter
// Fixed widths of the Q16.16 datapath, register indexes and controller states.
// ----------------------------------------------------------------------------
package kfm_pkg;

    // Field widths fixed by the data format.
    localparam int DATA_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_W    = 16;
    localparam int GAIN_W    = FRAC_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 5;

    // Last step of the serial divider and of the serial multipliers.
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    // One in Q16.16, held at gain width.
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

    // Register reset values: q = 0.1, r = 1.0.
    localparam logic [DATA_W-1:0] Q_RESET = 32'd6554;
    localparam logic [DATA_W-1:0] R_RESET = 32'd65536;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PROCESS_NOISE = 2'd0;
    localparam t_cfg_idx REG_MEASURE_NOISE = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIOR,
        ST_DENOM,
        ST_DIV,
        ST_MUL,
        ST_WRITE
    } t_state;

endpackage

### src/kfm_if.sv
// ----------------------------------------------------------------------------
// kfm_if: handshake channels of the multichannel Kalman filter
// Sample input, estimate output and register write channels.
// ----------------------------------------------------------------------------
interface kfm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 chip_index;
    logic                                 channel_index;
    logic signed [kfm_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, chip_index, channel_index, sample, input ready);
    modport sink   (input valid, chip_index, channel_index, sample, output ready);
endinterface

interface kfm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [kfm_pkg::DATA_W-1:0]   estimate;

    modport source (output valid, estimate, input ready);
    modport sink   (input valid, estimate, output ready);
endinterface

interface kfm_cfg_if;
    logic                          valid;
    logic                          ready;
    kfm_pkg::t_cfg_idx             index;
    logic [kfm_pkg::DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/scalar_kalman_filter_multichannel.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_multichannel: per-channel scalar Kalman filter
// A channel whose estimate is zero returns its sample unfiltered, as Q16.16;
// any other sample goes through an update step, set by the 17-step bit-serial
// gain divider followed by the two 17-step bit-serial multipliers. A new sample
// is taken only once the last result has gone into the output register.
// Reset (synchronous, active low) clears all estimates and covariances and
// loads q = 0.1 and r = 1.0; registers may be written from the next cycle on.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_multichannel #(
    parameter int CHIP_COUNT        = 2,
    parameter int CHANNELS_PER_CHIP = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kfm_in_if.sink    i_in,
    kfm_out_if.source o_out,
    kfm_cfg_if.sink   i_cfg
);

    localparam int LANES  = CHIP_COUNT * CHANNELS_PER_CHIP;
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int DW     = kfm_pkg::DATA_W;
    localparam int GW     = kfm_pkg::GAIN_W;

    // Configuration registers.
    logic [DW-1:0] r_q;
    logic [DW-1:0] r_r;

    // Per-channel state.
    logic [DW-1:0] r_est_mem [LANES];
    logic [DW-1:0] r_cov_mem [LANES];

    // Controller.
    kfm_pkg::t_state r_state, n_state;
    logic [kfm_pkg::CNT_W-1:0] r_cnt;

    // Datapath registers.
    logic [LANE_W-1:0]                   r_lane;
    logic signed [kfm_pkg::SAMPLE_W-1:0] r_x;
    logic                                r_load;
    logic [DW-1:0]                       r_est_old;
    logic [DW-1:0]                       r_prior;
    logic signed [DW:0]                  r_diff;
    logic [DW:0]                         r_denom;
    logic                                r_dzero;
    logic [DW:0]                         r_mag;
    logic [DW+1:0]                       r_rem;
    logic                                r_inbit;
    logic [GW-1:0]                       r_gain;
    logic [GW-1:0]                       r_gsh;
    logic [GW-1:0]                       r_csh;
    logic [DW:0]                         r_acc_e;
    logic                                r_lo_e;
    logic [DW-1:0]                       r_acc_c;
    logic                                r_lo_c;

    // Output register.
    logic          r_out_valid;
    logic [DW-1:0] r_out_est;

    // Combinational signals.
    logic                  w_chip_m;
    logic                  w_chan_m;
    logic [LANE_W:0]       w_lane_sum;
    logic                  w_in_xfer;
    logic                  w_out_free;
    logic [DW-1:0]         w_x32;
    logic [DW-1:0]         w_est_rd;
    logic [DW:0]           w_prior_sum;
    logic [DW-1:0]         w_prior;
    logic [DW+1:0]         w_rem_sh;
    logic                  w_ge;
    logic [GW-1:0]         w_gain_next;
    logic [DW+1:0]         w_sum_e;
    logic [DW:0]           w_sum_c;
    logic [DW+1:0]         w_step;
    logic [DW+1:0]         w_est_upd;
    logic [DW:0]           w_cov_prod;
    logic [DW-1:0]         w_result;

    // Channel routing; indexes reduce modulo their counts.
    assign w_chip_m   = (CHIP_COUNT > 1) ? i_in.chip_index : 1'b0;
    assign w_chan_m   = (CHANNELS_PER_CHIP > 1) ? i_in.channel_index : 1'b0;
    assign w_lane_sum = (LANE_W+1)'(w_chip_m) * (LANE_W+1)'(CHANNELS_PER_CHIP)
                      + (LANE_W+1)'(w_chan_m);

    // Handshakes.
    assign i_in.ready  = (r_state == kfm_pkg::ST_IDLE);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.estimate = r_out_est;

    // Sample as Q16.16 and the stored estimate of the active channel.
    assign w_x32    = {r_x, {kfm_pkg::FRAC_W{1'b0}}};
    assign w_est_rd = r_est_mem[r_lane];

    // Prior covariance, saturated to 32 bits.
    assign w_prior_sum = {1'b0, r_cov_mem[r_lane]} + {1'b0, r_q};
    assign w_prior     = w_prior_sum[DW] ? {DW{1'b1}} : w_prior_sum[DW-1:0];

    // One restoring division step per cycle.
    assign w_rem_sh    = {r_rem[DW:0], r_inbit};
    assign w_ge        = (w_rem_sh >= {1'b0, r_denom});
    assign w_gain_next = r_dzero ? '0 : {r_gain[GW-2:0], w_ge};

    // One bit of each multiplier per cycle, low gain bit first.
    assign w_sum_e = {1'b0, r_acc_e} + (r_gsh[0] ? {1'b0, r_mag} : '0);
    assign w_sum_c = {1'b0, r_acc_c} + (r_csh[0] ? {1'b0, r_prior} : '0);

    // Final estimate and covariance, products taken down by 16 bits.
    assign w_step     = {r_acc_e, r_lo_e};
    assign w_est_upd  = r_diff[DW] ? ({{2{r_est_old[DW-1]}}, r_est_old} - w_step)
                                   : ({{2{r_est_old[DW-1]}}, r_est_old} + w_step);
    assign w_cov_prod = {r_acc_c, r_lo_c};
    assign w_result   = r_load ? w_x32 : w_est_upd[DW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            kfm_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = kfm_pkg::ST_PRIOR;
                end
            end
            kfm_pkg::ST_PRIOR: begin
                n_state = (w_est_rd == '0) ? kfm_pkg::ST_WRITE : kfm_pkg::ST_DENOM;
            end
            kfm_pkg::ST_DENOM: begin
                n_state = kfm_pkg::ST_DIV;
            end
            kfm_pkg::ST_DIV: begin
                if (r_cnt == kfm_pkg::CNT_LAST) begin
                    n_state = kfm_pkg::ST_MUL;
                end
            end
            kfm_pkg::ST_MUL: begin
                if (r_cnt == kfm_pkg::CNT_LAST) begin
                    n_state = kfm_pkg::ST_WRITE;
                end
            end
            kfm_pkg::ST_WRITE: begin
                if (w_out_free) begin
                    n_state = kfm_pkg::ST_IDLE;
                end
            end
            default: n_state = kfm_pkg::ST_IDLE;
        endcase
    end

    // Controller state and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kfm_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == kfm_pkg::ST_DIV || r_state == kfm_pkg::ST_MUL)
                && r_cnt != kfm_pkg::CNT_LAST) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= kfm_pkg::Q_RESET;
            r_r <= kfm_pkg::R_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                kfm_pkg::REG_PROCESS_NOISE: r_q <= i_cfg.data;
                kfm_pkg::REG_MEASURE_NOISE: r_r <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Datapath: capture, setup, serial divide, serial multiply.
    always_ff @(posedge i_clk) begin
        case (r_state)
            kfm_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    r_lane <= w_lane_sum[LANE_W-1:0];
                    r_x    <= i_in.sample;
                end
            end
            kfm_pkg::ST_PRIOR: begin
                r_load    <= (w_est_rd == '0);
                r_est_old <= w_est_rd;
                r_prior   <= w_prior;
                r_diff    <= {w_x32[DW-1], w_x32} - {w_est_rd[DW-1], w_est_rd};
            end
            kfm_pkg::ST_DENOM: begin
                r_denom <= {1'b0, r_prior} + {1'b0, r_r};
                r_dzero <= (r_prior == '0) && (r_r == '0);
                r_mag   <= r_diff[DW] ? (DW+1)'(-r_diff) : (DW+1)'(r_diff);
                r_rem   <= {2'b00, 1'b0, r_prior[DW-1:1]};
                r_inbit <= r_prior[0];
            end
            kfm_pkg::ST_DIV: begin
                r_rem   <= w_ge ? (w_rem_sh - {1'b0, r_denom}) : w_rem_sh;
                r_inbit <= 1'b0;
                r_gain  <= {r_gain[GW-2:0], w_ge};
                if (r_cnt == kfm_pkg::CNT_LAST) begin
                    r_gsh   <= w_gain_next;
                    r_csh   <= kfm_pkg::GAIN_ONE - w_gain_next;
                    r_acc_e <= '0;
                    r_acc_c <= '0;
                end
            end
            kfm_pkg::ST_MUL: begin
                r_gsh   <= r_gsh >> 1;
                r_csh   <= r_csh >> 1;
                r_acc_e <= w_sum_e[DW+1:1];
                r_lo_e  <= w_sum_e[0];
                r_acc_c <= w_sum_c[DW:1];
                r_lo_c  <= w_sum_c[0];
            end
            default: ;
        endcase
    end

    // Channel state update at the end of a step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_est_mem[i] <= '0;
                r_cov_mem[i] <= '0;
            end
        end else if (r_state == kfm_pkg::ST_WRITE && w_out_free) begin
            r_est_mem[r_lane] <= w_result;
            if (!r_load) begin
                r_cov_mem[r_lane] <= w_cov_prod[DW-1:0];
            end
        end
    end

    // Output register; holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == kfm_pkg::ST_WRITE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == kfm_pkg::ST_WRITE && w_out_free) begin
            r_out_est <= w_result;
        end
    end

endmodule

### src/kfm_checker.sv
// ----------------------------------------------------------------------------
// kfm_checker: port-level checks of the multichannel Kalman filter
// Watches the sample and estimate channels and is bound to the top level.
// ----------------------------------------------------------------------------
module kfm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [kfm_pkg::DATA_W-1:0] i_out_estimate
);

    // A sample is worked on alone: input closes after each transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready ##1 !i_in_ready)
        else $error("input reopened while a sample was in progress");

    // A waiting estimate stays put until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_estimate)))
        else $error("estimate dropped or changed while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("estimate valid right after reset");

    // No result appears without a sample having been taken first.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && i_in_ready) |=> !i_out_valid)
        else $error("estimate appeared with no sample in progress");

endmodule

bind scalar_kalman_filter_multichannel kfm_checker u_kfm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_estimate (o_out.estimate)
);
